// ===== hw/rtl/swmv_pkg.sv =====
// ----------------------------------------------------------------------------
// Sliding window mean and variance: shared definitions
// Window depth, field widths and derived widths for the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package swmv_pkg;

    localparam int Window    = 180;

    localparam int SampleW   = 24;
    localparam int CountOutW = 8;
    localparam int MeanW     = 32;
    localparam int VarW      = 48;

    localparam int SlotW     = (Window > 1) ? $clog2(Window) : 1;
    localparam int CountW    = $clog2(Window + 1);
    localparam int SumW      = 32;
    localparam int SqW       = 56;
    localparam int MulW      = 32;
    localparam int ProdW     = 2 * MulW;
    localparam int NumW      = 64;
    localparam int DivW      = 2 * CountW;

    localparam int MeanSteps = (SumW + 8) / 2;
    localparam int VarSteps  = NumW / 2;
    localparam int StepW     = $clog2(VarSteps + 1);

endpackage

`default_nettype wire

// ===== hw/rtl/swmv_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module swmv_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  wire logic                                    aclk,
    input  wire logic                                    wr_en,
    input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] wr_addr,
    input  wire logic [Width-1:0]                        wr_data,
    input  wire logic                                    rd_en,
    input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] rd_addr,
    output logic      [Width-1:0]                        rd_data
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sliding_window_mean_variance.sv =====
// ----------------------------------------------------------------------------
// Sliding window mean and sample variance
// Keeps the last Window samples in a RAM ring with exact running sum and sum
// of squares; returns count, floored Q8 mean and floored sample variance.
// ----------------------------------------------------------------------------
//   channel | ports                         | payload
//   --------+-------------------------------+----------------------------------
//   input   | s_valid / s_ready             | s_sample_us
//   output  | m_valid / m_ready             | m_sample_count, m_mean_q8,
//           |                               | m_variance
//
//   Per word: accept, then the ring read and the multiply sequence on one
//   shared 32x32 multiplier, then the mean and variance divisions on a
//   2-bit-per-cycle divider shared by both, then hand off; with one sample
//   held the variance pass is skipped. s_ready is high only when idle.
//   A result waiting on m_ready holds the next one in the done state, and the
//   input with it.
//   Reset clears the sums, counters and state; the ring needs no clear.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_mean_variance (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [swmv_pkg::SampleW-1:0]     s_sample_us,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic      [swmv_pkg::CountOutW-1:0]   m_sample_count,
    output logic      [swmv_pkg::MeanW-1:0]       m_mean_q8,
    output logic      [swmv_pkg::VarW-1:0]        m_variance
);

    import swmv_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_OLDSQ = 4'd1;
    localparam logic [3:0] ST_NEWSQ = 4'd2;
    localparam logic [3:0] ST_SUMSQ = 4'd3;
    localparam logic [3:0] ST_M0    = 4'd4;
    localparam logic [3:0] ST_M1    = 4'd5;
    localparam logic [3:0] ST_M2    = 4'd6;
    localparam logic [3:0] ST_M3    = 4'd7;
    localparam logic [3:0] ST_M4    = 4'd8;
    localparam logic [3:0] ST_DIVM  = 4'd9;
    localparam logic [3:0] ST_DIVV  = 4'd10;
    localparam logic [3:0] ST_DONE  = 4'd11;

    logic [3:0]           state_reg, state_next;
    logic [SlotW-1:0]     write_slot_reg, write_slot_next;
    logic [CountW-1:0]    fill_count_reg, fill_count_next;
    logic [SumW-1:0]      running_sum_reg, running_sum_next;
    logic [SqW-1:0]       running_sum_squares_reg, running_sum_squares_next;
    logic                 m_valid_reg, m_valid_next;

    logic [SampleW-1:0]   x_reg, x_next;
    logic [ProdW-1:0]     prod_reg;
    logic [NumW-1:0]      num_reg, num_next;
    logic [DivW-1:0]      den_reg, den_next;
    logic [DivW-1:0]      div_reg, div_next;
    logic [DivW:0]        rem_reg, rem_next;
    logic [NumW-1:0]      quo_reg, quo_next;
    logic [StepW-1:0]     cnt_reg, cnt_next;
    logic [MeanW-1:0]     mean_res_reg, mean_res_next;
    logic [VarW-1:0]      var_res_reg, var_res_next;
    logic [CountOutW-1:0] m_count_reg, m_count_next;
    logic [MeanW-1:0]     m_mean_reg, m_mean_next;
    logic [VarW-1:0]      m_var_reg, m_var_next;

    logic [MulW-1:0]      mul_a, mul_b;
    logic [DivW:0]        step_rem;
    logic [NumW-1:0]      step_quo;
    logic                 ram_wr_en, ram_rd_en;
    logic [SampleW-1:0]   ram_rd_data;
    logic [SampleW-1:0]   old_sample;
    logic                 window_full;
    logic                 in_accept;

    assign in_accept   = s_valid && s_ready;
    assign s_ready     = (state_reg == ST_IDLE);
    assign window_full = (fill_count_reg == CountW'(Window));
    assign old_sample  = window_full ? ram_rd_data : '0;
    assign ram_rd_en   = in_accept;
    assign ram_wr_en   = (state_reg == ST_NEWSQ);

    swmv_ram #(
        .Width (SampleW),
        .Depth (Window)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (write_slot_reg),
        .wr_data (x_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (write_slot_reg),
        .rd_data (ram_rd_data)
    );

    // two restoring division steps per cycle
    always_comb begin
        step_rem = rem_reg;
        step_quo = quo_reg;
        for (int k = 0; k < 2; k++) begin
            step_rem = {step_rem[DivW-1:0], step_quo[NumW-1]};
            step_quo = {step_quo[NumW-2:0], 1'b0};
            if (step_rem >= {1'b0, div_reg}) begin
                step_rem    = step_rem - {1'b0, div_reg};
                step_quo[0] = 1'b1;
            end
        end
    end

    // multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_OLDSQ: begin
                mul_a = MulW'(old_sample);
                mul_b = MulW'(old_sample);
            end
            ST_NEWSQ: begin
                mul_a = MulW'(x_reg);
                mul_b = MulW'(x_reg);
            end
            ST_M0: begin
                mul_a = MulW'(fill_count_reg);
                mul_b = running_sum_squares_reg[MulW-1:0];
            end
            ST_M1: begin
                mul_a = MulW'(fill_count_reg);
                mul_b = MulW'(running_sum_squares_reg[SqW-1:MulW]);
            end
            ST_M2: begin
                mul_a = MulW'(running_sum_reg);
                mul_b = MulW'(running_sum_reg);
            end
            ST_M3: begin
                mul_a = MulW'(fill_count_reg);
                mul_b = MulW'(fill_count_reg - CountW'(1));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        state_next               = state_reg;
        write_slot_next          = write_slot_reg;
        fill_count_next          = fill_count_reg;
        running_sum_next         = running_sum_reg;
        running_sum_squares_next = running_sum_squares_reg;
        m_valid_next             = m_valid_reg;
        x_next                   = x_reg;
        num_next                 = num_reg;
        den_next                 = den_reg;
        div_next                 = div_reg;
        rem_next                 = rem_reg;
        quo_next                 = quo_reg;
        cnt_next                 = cnt_reg;
        mean_res_next            = mean_res_reg;
        var_res_next             = var_res_reg;
        m_count_next             = m_count_reg;
        m_mean_next              = m_mean_reg;
        m_var_next               = m_var_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    x_next     = s_sample_us;
                    state_next = ST_OLDSQ;
                end
            end
            ST_OLDSQ: begin
                running_sum_next = running_sum_reg - SumW'(old_sample);
                state_next       = ST_NEWSQ;
            end
            ST_NEWSQ: begin
                running_sum_squares_next = running_sum_squares_reg - prod_reg[SqW-1:0];
                running_sum_next         = running_sum_reg + SumW'(x_reg);
                if (!window_full) begin
                    fill_count_next = fill_count_reg + CountW'(1);
                end
                if (write_slot_reg == SlotW'(Window - 1)) begin
                    write_slot_next = '0;
                end else begin
                    write_slot_next = write_slot_reg + SlotW'(1);
                end
                state_next = ST_SUMSQ;
            end
            ST_SUMSQ: begin
                running_sum_squares_next = running_sum_squares_reg + prod_reg[SqW-1:0];
                state_next               = ST_M0;
            end
            ST_M0: begin
                state_next = ST_M1;
            end
            ST_M1: begin
                num_next   = prod_reg;
                state_next = ST_M2;
            end
            ST_M2: begin
                num_next   = num_reg + {prod_reg[NumW-MulW-1:0], {MulW{1'b0}}};
                state_next = ST_M3;
            end
            ST_M3: begin
                num_next   = num_reg - prod_reg;
                state_next = ST_M4;
            end
            ST_M4: begin
                den_next   = prod_reg[DivW-1:0];
                div_next   = DivW'(fill_count_reg);
                rem_next   = '0;
                quo_next   = {running_sum_reg, {(NumW-SumW){1'b0}}};
                cnt_next   = StepW'(MeanSteps);
                state_next = ST_DIVM;
            end
            ST_DIVM: begin
                rem_next = step_rem;
                quo_next = step_quo;
                cnt_next = cnt_reg - StepW'(1);
                if (cnt_reg == StepW'(1)) begin
                    mean_res_next = step_quo[MeanW-1:0];
                    if (fill_count_reg >= CountW'(2)) begin
                        div_next   = den_reg;
                        rem_next   = '0;
                        quo_next   = num_reg;
                        cnt_next   = StepW'(VarSteps);
                        state_next = ST_DIVV;
                    end else begin
                        var_res_next = '0;
                        state_next   = ST_DONE;
                    end
                end
            end
            ST_DIVV: begin
                rem_next = step_rem;
                quo_next = step_quo;
                cnt_next = cnt_reg - StepW'(1);
                if (cnt_reg == StepW'(1)) begin
                    var_res_next = step_quo[VarW-1:0];
                    state_next   = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_count_next = CountOutW'(fill_count_reg);
                    m_mean_next  = mean_res_reg;
                    m_var_next   = var_res_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg               <= ST_IDLE;
            write_slot_reg          <= '0;
            fill_count_reg          <= '0;
            running_sum_reg         <= '0;
            running_sum_squares_reg <= '0;
            m_valid_reg             <= 1'b0;
        end else begin
            state_reg               <= state_next;
            write_slot_reg          <= write_slot_next;
            fill_count_reg          <= fill_count_next;
            running_sum_reg         <= running_sum_next;
            running_sum_squares_reg <= running_sum_squares_next;
            m_valid_reg             <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg     <= ProdW'(mul_a) * ProdW'(mul_b);
        x_reg        <= x_next;
        num_reg      <= num_next;
        den_reg      <= den_next;
        div_reg      <= div_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        cnt_reg      <= cnt_next;
        mean_res_reg <= mean_res_next;
        var_res_reg  <= var_res_next;
        m_count_reg  <= m_count_next;
        m_mean_reg   <= m_mean_next;
        m_var_reg    <= m_var_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_sample_count = m_count_reg;
    assign m_mean_q8      = m_mean_reg;
    assign m_variance     = m_var_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_count_reg <= CountW'(Window))
        else $error("fill count above window depth");

    a_slot_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        write_slot_reg <= SlotW'(Window - 1))
        else $error("write slot out of ring");

    a_empty_sums: assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_count_reg == '0) |-> (running_sum_reg == '0 && running_sum_squares_reg == '0))
        else $error("sums nonzero with empty window");

    a_done_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && m_valid_reg && !m_ready) |=> (state_reg == ST_DONE))
        else $error("result dropped while output stalled");

endmodule

`default_nettype wire
